@@ rtl/wmip_pkg.sv @@
package wmip_pkg;

    // Default receive buffer depth in bytes.
    localparam int RX_DEPTH_DEF = 16;

    // Width of the WebSocket frame length and its down-counter.
    localparam int LEN_W = 64;

    // Result event codes.
    localparam logic [2:0] EV_NONE        = 3'd0;
    localparam logic [2:0] EV_CONNACK_OK  = 3'd1;
    localparam logic [2:0] EV_CONNACK_BAD = 3'd2;
    localparam logic [2:0] EV_PINGRESP    = 3'd3;
    localparam logic [2:0] EV_OTHER       = 3'd4;

    // MQTT control packet types (upper nibble of the first byte).
    localparam logic [3:0] PKT_CONNACK  = 4'h2;
    localparam logic [3:0] PKT_PINGRESP = 4'hD;

    // WebSocket opcodes whose payload carries MQTT bytes.
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;

    // Seven-bit length code that announces a 16-bit extended length.
    localparam logic [6:0] LEN7_EXT16 = 7'd126;

    // Extended length byte counts.
    localparam logic [3:0] EXT_NONE = 4'd0;
    localparam logic [3:0] EXT_16   = 4'd2;
    localparam logic [3:0] EXT_64   = 4'd8;

    // Return code reported when the CONNACK is too short to carry one.
    localparam logic [7:0] RC_SHORT = 8'hFF;

    // Frame header progress codes.
    localparam logic [1:0] HDR_FIRST  = 2'd0;
    localparam logic [1:0] HDR_SECOND = 2'd1;
    localparam logic [1:0] HDR_BODY   = 2'd2;

    // What the accumulator reports for one fed byte.
    typedef struct packed {
        logic [2:0] event_code;
        logic [7:0] code;
    } acc_res_t;

endpackage

@@ rtl/wmip_acc.sv @@
module wmip_acc #(
    parameter int RX_DEPTH = wmip_pkg::RX_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              feed,
    input  logic [7:0]        feed_byte,
    output wmip_pkg::acc_res_t res
);

    localparam int CNT_W = $clog2(RX_DEPTH + 1);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [7:0]       bytes_reg [4];
    logic [7:0]       bytes_next [4];
    logic [8:0]       total;
    logic             complete;

    // Store the byte while there is room and check for a whole packet.
    always_comb
    begin
        bytes_next = bytes_reg;
        count_next = count_reg;
        res.event_code = wmip_pkg::EV_NONE;
        res.code = 8'd0;
        if (count_reg < CNT_W'(RX_DEPTH))
        begin
            if (count_reg < CNT_W'(4))
            begin
                bytes_next[count_reg[1:0]] = feed_byte;
            end
            count_next = count_reg + CNT_W'(1);
        end
        total = 9'd2 + {1'b0, bytes_next[1]};
        complete = (count_next >= CNT_W'(2)) && (9'(count_next) >= total);
        if (complete)
        begin
            if (bytes_next[0][7:4] == wmip_pkg::PKT_CONNACK)
            begin
                res.code = (bytes_next[1] >= 8'd2) ? bytes_next[3] : wmip_pkg::RC_SHORT;
                res.event_code = (res.code == 8'd0) ? wmip_pkg::EV_CONNACK_OK
                                                    : wmip_pkg::EV_CONNACK_BAD;
            end
            else if (bytes_next[0][7:4] == wmip_pkg::PKT_PINGRESP)
            begin
                res.event_code = wmip_pkg::EV_PINGRESP;
            end
            else
            begin
                res.event_code = wmip_pkg::EV_OTHER;
            end
            count_next = '0;
        end
    end

    // Fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (feed)
        begin
            count_reg <= count_next;
        end
    end

    // Packet head bytes carry no reset.
    always_ff @(posedge clk)
    begin
        if (feed)
        begin
            bytes_reg <= bytes_next;
        end
    end

    // The fill count never passes the buffer depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(RX_DEPTH))
        else $error("accumulator fill count beyond depth");

endmodule

@@ rtl/ws_mqtt_inbound_parser.sv @@
// Inbound byte parser for an MQTT client over raw TCP or WebSocket.
// Input channel: one received byte per item (in_valid, in_stall, data_byte).
// Output channel: exactly one result item per input item (out_valid,
// out_stall, event_res, ack_code, frame_done). event_res is nonzero on
// the byte that completes an MQTT packet; frame_done marks the byte that
// ends a WebSocket frame.
// Configuration: websocket_mode is written over cfg_valid/cfg_ready; the
// user must do so only while the block is idle; the block does not enforce
// it. cfg_ready is always high. A byte's result is registered at the edge
// that accepts it. Throughput is one byte per cycle while the receiver
// does not stall, set by the single result register; the frame length
// down-counter and packet check are both combinational. When the receiver
// stalls a valid result, the result register holds and in_stall rises in
// the same cycle, so no byte is taken until the result is delivered. Reset
// clears parse state, selects raw mode and empties the output.
module ws_mqtt_inbound_parser #(
    parameter int RX_DEPTH = wmip_pkg::RX_DEPTH_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       websocket_mode,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [2:0] event_res,
    output logic [7:0] ack_code,
    output logic       frame_done
);

    localparam int LW = wmip_pkg::LEN_W;

    logic          mode_reg;
    logic [1:0]    hdr_reg;
    logic [1:0]    hdr_next;
    logic [3:0]    opcode_reg;
    logic [3:0]    opcode_next;
    logic [3:0]    ext_need_reg;
    logic [3:0]    ext_need_next;
    logic [3:0]    ext_cnt_reg;
    logic [3:0]    ext_cnt_next;
    logic [LW-1:0] remain_reg;
    logic [LW-1:0] remain_next;
    logic [LW-1:0] shifted;
    logic [6:0]    len7;
    logic          done;
    logic          feed;
    logic          accept;
    logic          out_valid_reg;
    logic [2:0]    event_reg;
    logic [7:0]    code_reg;
    logic          done_reg;
    wmip_pkg::acc_res_t acc_res;

    // Handshakes.
    assign cfg_ready = 1'b1;
    assign in_stall  = out_valid_reg && out_stall;
    assign accept    = in_valid && !in_stall;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= websocket_mode;
        end
    end

    // Frame deframer: in WebSocket mode header, extended length, then payload countdown; raw mode feeds every byte.
    always_comb
    begin
        hdr_next      = hdr_reg;
        opcode_next   = opcode_reg;
        ext_need_next = ext_need_reg;
        ext_cnt_next  = ext_cnt_reg;
        remain_next   = remain_reg;
        done          = 1'b0;
        feed          = 1'b0;
        len7          = data_byte[6:0];
        shifted       = {remain_reg[LW-9:0], data_byte};
        if (!mode_reg)
        begin
            feed = 1'b1;
        end
        else if (hdr_reg == wmip_pkg::HDR_FIRST)
        begin
            opcode_next = data_byte[3:0];
            hdr_next    = wmip_pkg::HDR_SECOND;
        end
        else if (hdr_reg == wmip_pkg::HDR_SECOND)
        begin
            hdr_next     = wmip_pkg::HDR_BODY;
            ext_cnt_next = 4'd0;
            remain_next  = '0;
            if (len7 < wmip_pkg::LEN7_EXT16)
            begin
                remain_next   = LW'(len7);
                ext_need_next = wmip_pkg::EXT_NONE;
                if (len7 == 7'd0)
                begin
                    hdr_next = wmip_pkg::HDR_FIRST;
                    done     = 1'b1;
                end
            end
            else if (len7 == wmip_pkg::LEN7_EXT16)
            begin
                ext_need_next = wmip_pkg::EXT_16;
            end
            else
            begin
                ext_need_next = wmip_pkg::EXT_64;
            end
        end
        else if (ext_need_reg != wmip_pkg::EXT_NONE)
        begin
            remain_next  = shifted;
            ext_cnt_next = ext_cnt_reg + 4'd1;
            if (ext_cnt_next >= ext_need_reg)
            begin
                ext_need_next = wmip_pkg::EXT_NONE;
                if (shifted == '0)
                begin
                    hdr_next = wmip_pkg::HDR_FIRST;
                    done     = 1'b1;
                end
            end
        end
        else
        begin
            // Payload byte: only text and binary frames carry MQTT.
            feed = (opcode_reg == wmip_pkg::OP_BINARY) || (opcode_reg == wmip_pkg::OP_TEXT);
            remain_next = remain_reg - LW'(1);
            if (remain_reg <= LW'(1))
            begin
                hdr_next = wmip_pkg::HDR_FIRST;
                done     = 1'b1;
            end
        end
    end

    // Deframer state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg      <= wmip_pkg::HDR_FIRST;
            opcode_reg   <= 4'd0;
            ext_need_reg <= wmip_pkg::EXT_NONE;
            ext_cnt_reg  <= 4'd0;
            remain_reg   <= '0;
        end
        else if (accept)
        begin
            hdr_reg      <= hdr_next;
            opcode_reg   <= opcode_next;
            ext_need_reg <= ext_need_next;
            ext_cnt_reg  <= ext_cnt_next;
            remain_reg   <= remain_next;
        end
    end

    // MQTT packet accumulator.
    wmip_acc #(
        .RX_DEPTH(RX_DEPTH)
    ) u_acc (
        .clk      (clk),
        .rst_n    (rst_n),
        .feed     (accept && feed),
        .feed_byte(data_byte),
        .res      (acc_res)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            event_reg <= feed ? acc_res.event_code : wmip_pkg::EV_NONE;
            code_reg  <= feed ? acc_res.code : 8'd0;
            done_reg  <= done;
        end
    end

    assign out_valid  = out_valid_reg;
    assign event_res  = event_reg;
    assign ack_code   = code_reg;
    assign frame_done = done_reg;

    // Header progress never takes the unused code.
    assert property (@(posedge clk) disable iff (!rst_n)
        hdr_reg != 2'd3)
        else $error("frame header progress out of range");

    // A return code only travels with a CONNACK event.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (event_reg != wmip_pkg::EV_CONNACK_OK)
            && (event_reg != wmip_pkg::EV_CONNACK_BAD) |-> code_reg == 8'd0)
        else $error("return code without CONNACK");

    // Accepted CONNACK means a zero code, refused a nonzero one.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (event_reg == wmip_pkg::EV_CONNACK_BAD) |-> code_reg != 8'd0)
        else $error("refused CONNACK with zero code");

endmodule

@@ bench/ws_mqtt_inbound_parser_tb.sv @@
module ws_mqtt_inbound_parser_tb;

    import wmip_pkg::*;

    localparam int RX_DEPTH = RX_DEPTH_DEF;
    localparam int DIR_COUNT = 25;
    localparam int RANDOM_ITEMS = 560;
    localparam int CLOSING_ITEMS = 80;
    localparam int TIMEOUT_UNITS = 4_000_000;

    // Seven-bit length code that announces a 64-bit extended length.
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    // One result item as the block reports it.
    typedef struct packed {
        logic [2:0] ev;
        logic [7:0] rc;
        logic       fd;
    } parse_res_t;

    // One row of the directed stimulus: a byte or a mode write, and where it
    // is obvious, the result the byte must produce.
    typedef struct packed {
        logic       is_cfg;
        logic [7:0] value;
        logic       typed;
        logic [2:0] ev;
        logic [7:0] rc;
        logic       fd;
    } dir_row_t;

    localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
        // Raw mode: CONNACK accepted.
        '{1'b0, {PKT_CONNACK, 4'h0}, 1'b0, EV_NONE, 8'h00, 1'b0},
        '{1'b0, 8'h02, 1'b0, EV_NONE, 8'h00, 1'b0},
        '{1'b0, 8'h00, 1'b0, EV_NONE, 8'h00, 1'b0},
        '{1'b0, 8'h00, 1'b1, EV_CONNACK_OK, 8'h00, 1'b0},
        // CONNACK refused with a return code.
        '{1'b0, {PKT_CONNACK, 4'h0}, 1'b0, EV_NONE, 8'h00, 1'b0},
        '{1'b0, 8'h02, 1'b0, EV_NONE, 8'h00, 1'b0},
        '{1'b0, 8'h00, 1'b0, EV_NONE, 8'h00, 1'b0},
        '{1'b0, 8'h05, 1'b1, EV_CONNACK_BAD, 8'h05, 1'b0},
        // CONNACK too short to carry a return code.
        '{1'b0, {PKT_CONNACK, 4'h0}, 1'b0, EV_NONE, 8'h00, 1'b0},
        '{1'b0, 8'h00, 1'b1, EV_CONNACK_BAD, RC_SHORT, 1'b0},
        // PINGRESP.
        '{1'b0, {PKT_PINGRESP, 4'h0}, 1'b0, EV_NONE, 8'h00, 1'b0},
        '{1'b0, 8'h00, 1'b1, EV_PINGRESP, 8'h00, 1'b0},
        // Other packet type, all-ones first byte.
        '{1'b0, 8'hFF, 1'b0, EV_NONE, 8'h00, 1'b0},
        '{1'b0, 8'h00, 1'b1, EV_OTHER, 8'h00, 1'b0},
        // Switch to WebSocket framing.
        '{1'b1, 8'h01, 1'b0, EV_NONE, 8'h00, 1'b0},
        // Empty binary frame with the mask bit set in the length byte.
        '{1'b0, {4'h8, OP_BINARY}, 1'b0, EV_NONE, 8'h00, 1'b0},
        '{1'b0, 8'h80, 1'b1, EV_NONE, 8'h00, 1'b1},
        // Empty text frame announced through a 16-bit extended length.
        '{1'b0, {4'h8, OP_TEXT}, 1'b0, EV_NONE, 8'h00, 1'b0},
        '{1'b0, {1'b0, LEN7_EXT16}, 1'b0, EV_NONE, 8'h00, 1'b0},
        '{1'b0, 8'h00, 1'b0, EV_NONE, 8'h00, 1'b0},
        '{1'b0, 8'h00, 1'b1, EV_NONE, 8'h00, 1'b1},
        // Binary frame carrying a PINGRESP, ending on the same byte.
        '{1'b0, {4'h8, OP_BINARY}, 1'b0, EV_NONE, 8'h00, 1'b0},
        '{1'b0, 8'h02, 1'b0, EV_NONE, 8'h00, 1'b0},
        '{1'b0, {PKT_PINGRESP, 4'h0}, 1'b0, EV_NONE, 8'h00, 1'b0},
        '{1'b0, 8'h00, 1'b1, EV_PINGRESP, 8'h00, 1'b1}
    };

    logic       clk = 1'b0;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] data_byte;
    logic       cfg_valid;
    logic       cfg_ready;
    logic       websocket_mode;
    logic       out_valid;
    logic       out_stall;
    logic [2:0] event_res;
    logic [7:0] ack_code;
    logic       frame_done;

    // Shadow parse state of the block.
    logic        pf_ws;
    logic [1:0]  pf_hdr;
    logic [3:0]  pf_opcode;
    logic [3:0]  pf_ext_need;
    logic [3:0]  pf_ext_got;
    logic [63:0] pf_len;
    logic [63:0] pf_cnt;
    logic [4:0]  pf_fill;
    logic [7:0]  pf_pkt [4];

    // Results still owed by the block, oldest first.
    parse_res_t parse_results_q [$];

    // Stimulus streams: MQTT bytes still to send, and the rest of the current
    // frame on the wire. Bit 8 of a frame entry marks a payload slot that is
    // filled from the MQTT stream when it goes out, so switching modes in the
    // middle of a frame never reorders the MQTT stream.
    logic [7:0] mqtt_q [$];
    logic [8:0] frame_q [$];
    bit         oversize_next;

    bit src_idle_on;
    bit snk_idle_on;
    int sink_hold = 0;
    int error_count = 0;
    int results_seen = 0;

    ws_mqtt_inbound_parser #(
        .RX_DEPTH(RX_DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .websocket_mode(websocket_mode),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .event_res(event_res),
        .ack_code(ack_code),
        .frame_done(frame_done)
    );

    always #10 clk = ~clk;

    task automatic flag_mismatch(input string msg);
        if (error_count < 100)
        begin
            $display("MISMATCH at %0t: %s", $time, msg);
        end
        error_count++;
    endtask

    // Feeds one byte to the packet accumulator and reports a finished packet.
    function automatic parse_res_t accumulate_mqtt(input logic [7:0] b);
        parse_res_t r;
        logic [8:0] total;
        r = '0;
        if (pf_fill < RX_DEPTH)
        begin
            if (pf_fill < 4)
            begin
                pf_pkt[pf_fill[1:0]] = b;
            end
            pf_fill = pf_fill + 1'b1;
        end
        if (pf_fill >= 2)
        begin
            total = 9'd2 + pf_pkt[1];
            if (pf_fill >= total)
            begin
                if (pf_pkt[0][7:4] == PKT_CONNACK)
                begin
                    r.rc = (pf_pkt[1] >= 2) ? pf_pkt[3] : RC_SHORT;
                    r.ev = (r.rc == 8'h00) ? EV_CONNACK_OK : EV_CONNACK_BAD;
                end
                else if (pf_pkt[0][7:4] == PKT_PINGRESP)
                begin
                    r.ev = EV_PINGRESP;
                end
                else
                begin
                    r.ev = EV_OTHER;
                end
                pf_fill = '0;
            end
        end
        return r;
    endfunction

    // Deframes one received byte and returns the result it must produce.
    function automatic parse_res_t deframe_and_parse(input logic [7:0] b);
        parse_res_t r;
        logic [6:0] len7;
        r = '0;
        len7 = b[6:0];
        if (!pf_ws)
        begin
            r = accumulate_mqtt(b);
        end
        else if (pf_hdr == HDR_FIRST)
        begin
            pf_opcode = b[3:0];
            pf_hdr = HDR_SECOND;
        end
        else if (pf_hdr == HDR_SECOND)
        begin
            pf_hdr = HDR_BODY;
            pf_ext_got = '0;
            pf_cnt = '0;
            pf_len = '0;
            if (len7 < LEN7_EXT16)
            begin
                pf_len = 64'(len7);
                pf_ext_need = EXT_NONE;
                if (len7 == 7'd0)
                begin
                    pf_hdr = HDR_FIRST;
                    r.fd = 1'b1;
                end
            end
            else if (len7 == LEN7_EXT16)
            begin
                pf_ext_need = EXT_16;
            end
            else
            begin
                pf_ext_need = EXT_64;
            end
        end
        else if (pf_ext_need != EXT_NONE)
        begin
            pf_len = {pf_len[55:0], b};
            pf_ext_got = pf_ext_got + 1'b1;
            if (pf_ext_got >= pf_ext_need)
            begin
                pf_ext_need = EXT_NONE;
                if (pf_len == 64'd0)
                begin
                    pf_hdr = HDR_FIRST;
                    r.fd = 1'b1;
                end
            end
        end
        else
        begin
            pf_cnt = pf_cnt + 64'd1;
            if (pf_opcode == OP_BINARY || pf_opcode == OP_TEXT)
            begin
                r = accumulate_mqtt(b);
            end
            if (pf_cnt >= pf_len)
            begin
                pf_hdr = HDR_FIRST;
                r.fd = 1'b1;
            end
        end
        return r;
    endfunction

    // Appends one well-formed MQTT packet to the MQTT stream. Most are short;
    // some reach up to the buffer depth; the oversize one is requested at the end.
    function automatic void add_mqtt_packet();
        logic [3:0] kind;
        logic [7:0] b;
        int rem;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 40)
        begin
            kind = PKT_CONNACK;
        end
        else if (pick < 65)
        begin
            kind = PKT_PINGRESP;
        end
        else
        begin
            kind = 4'($urandom);
        end
        if (oversize_next)
        begin
            rem = $urandom_range(RX_DEPTH - 1, 255);
            oversize_next = 1'b0;
        end
        else if ($urandom_range(0, 4) == 0)
        begin
            rem = $urandom_range(0, RX_DEPTH - 2);
        end
        else
        begin
            rem = $urandom_range(0, 4);
        end
        mqtt_q.push_back({kind, 4'($urandom)});
        mqtt_q.push_back(8'(rem));
        for (int i = 0; i < rem; i++)
        begin
            b = 8'($urandom);
            // The return code byte is zero half the time.
            if (i == 1 && $urandom_range(0, 1) == 1)
            begin
                b = 8'h00;
            end
            mqtt_q.push_back(b);
        end
    endfunction

    // Appends one server frame, with a random mask bit but no masking key, to the wire stream.
    function automatic void add_ws_frame();
        logic [3:0]  op;
        logic [63:0] len;
        logic        carries;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            op = OP_BINARY;
        end
        else if (pick < 70)
        begin
            op = OP_TEXT;
        end
        else
        begin
            op = 4'($urandom);
        end
        carries = (op == OP_BINARY || op == OP_TEXT);
        pick = $urandom_range(0, 99);
        if (pick < 8)
        begin
            len = 64'd0;
        end
        else if (!carries && pick < 12)
        begin
            len = 64'($urandom_range(126, 300));
        end
        else
        begin
            len = 64'($urandom_range(1, 12));
        end
        frame_q.push_back({1'b0, 4'($urandom), op});
        pick = $urandom_range(0, 99);
        if (len < 64'd126 && pick < 65)
        begin
            frame_q.push_back({1'b0, 1'($urandom), len[6:0]});
        end
        else if (pick < 85)
        begin
            frame_q.push_back({1'b0, 1'($urandom), LEN7_EXT16});
            frame_q.push_back({1'b0, len[15:8]});
            frame_q.push_back({1'b0, len[7:0]});
        end
        else
        begin
            frame_q.push_back({1'b0, 1'($urandom), LEN7_EXT64});
            for (int i = 7; i >= 0; i--)
            begin
                frame_q.push_back({1'b0, len[8*i +: 8]});
            end
        end
        for (int i = 0; i < int'(len); i++)
        begin
            frame_q.push_back(carries ? 9'h100 : {1'b0, 8'($urandom)});
        end
    endfunction

    // Next byte on the wire for the current mode.
    function automatic logic [7:0] next_wire_byte();
        logic [8:0] slot;
        slot = 9'h100;
        if (pf_ws)
        begin
            if (frame_q.size() == 0)
            begin
                add_ws_frame();
            end
            slot = frame_q.pop_front();
        end
        if (slot[8])
        begin
            if (mqtt_q.size() == 0)
            begin
                add_mqtt_packet();
            end
            slot = {1'b0, mqtt_q.pop_front()};
        end
        return slot[7:0];
    endfunction

    // Sends one byte item and records the result it owes.
    task automatic send_byte(input logic [7:0] b, input logic typed, input parse_res_t want);
        parse_res_t predicted;
        if (src_idle_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= b;
        do @(posedge clk); while (in_stall);
        predicted = deframe_and_parse(b);
        parse_results_q.push_back(typed ? want : predicted);
    endtask

    // Writes the mode register once every owed result has come back.
    task automatic set_mode(input logic m);
        in_valid <= 1'b0;
        while (parse_results_q.size() != 0) @(posedge clk);
        cfg_valid <= 1'b1;
        websocket_mode <= m;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        pf_ws = m;
    endtask

    task automatic check_parse_result();
        parse_res_t want;
        results_seen++;
        if (parse_results_q.size() == 0)
        begin
            flag_mismatch($sformatf("result %0d not expected: ev=%0d rc=%02h fd=%0b",
                results_seen, event_res, ack_code, frame_done));
        end
        else
        begin
            want = parse_results_q.pop_front();
            if (event_res !== want.ev)
            begin
                flag_mismatch($sformatf("result %0d event_res=%0d, want %0d",
                    results_seen, event_res, want.ev));
            end
            if (ack_code !== want.rc)
            begin
                flag_mismatch($sformatf("result %0d ack_code=%02h, want %02h",
                    results_seen, ack_code, want.rc));
            end
            if (frame_done !== want.fd)
            begin
                flag_mismatch($sformatf("result %0d frame_done=%0b, want %0b",
                    results_seen, frame_done, want.fd));
            end
        end
    endtask

    // Result side: check each delivered item, then stall in random bursts.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                check_parse_result();
            end
            if (sink_hold > 0)
            begin
                out_stall <= 1'b1;
                sink_hold--;
            end
            else if (snk_idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                sink_hold = $urandom_range(0, 6);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // Stimulus: reset, directed rows, random phases, closing stretch.
    initial
    begin
        int sent;
        int phase_len;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        data_byte <= 8'h00;
        cfg_valid <= 1'b0;
        websocket_mode <= 1'b0;
        pf_ws = 1'b0;
        pf_hdr = HDR_FIRST;
        pf_opcode = '0;
        pf_ext_need = EXT_NONE;
        pf_ext_got = '0;
        pf_len = '0;
        pf_cnt = '0;
        pf_fill = '0;
        oversize_next = 1'b0;
        src_idle_on = 1'b1;
        snk_idle_on = 1'b1;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows.
        for (int i = 0; i < DIR_COUNT; i++)
        begin
            if (DIR_ROWS[i].is_cfg)
            begin
                set_mode(DIR_ROWS[i].value[0]);
            end
            else
            begin
                send_byte(DIR_ROWS[i].value, DIR_ROWS[i].typed,
                    {DIR_ROWS[i].ev, DIR_ROWS[i].rc, DIR_ROWS[i].fd});
            end
        end

        // Random phases; the mode may change in the middle of a frame or packet.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            set_mode(1'($urandom_range(0, 1)));
            src_idle_on = ($urandom_range(0, 3) != 0);
            snk_idle_on = ($urandom_range(0, 3) != 0);
            phase_len = $urandom_range(30, 120);
            repeat (phase_len) send_byte(next_wire_byte(), 1'b0, '0);
            sent += phase_len;
        end

        // Closing stretch at full rate in raw mode, ending in an oversize
        // packet whose tail is discarded and never completes.
        src_idle_on = 1'b0;
        snk_idle_on = 1'b0;
        set_mode(1'b0);
        oversize_next = 1'b1;
        repeat (CLOSING_ITEMS) send_byte(next_wire_byte(), 1'b0, '0);

        in_valid <= 1'b0;
        while (parse_results_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (error_count == 0)
        begin
            $display("ws_mqtt_inbound_parser_tb: PASS");
        end
        else
        begin
            $display("ws_mqtt_inbound_parser_tb: FAIL");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #TIMEOUT_UNITS;
        $display("ws_mqtt_inbound_parser_tb: FAIL");
        $finish;
    end

endmodule
